// ----- rtl/slipcrc_pkg.sv -----
// Shared constants, types and the CRC-16 byte update for the SLIP/CRC16 deframer.
// No dependencies.
package slipcrc_pkg;

   localparam int unsigned MAX_FRAME_BYTES = 1024;
   localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int unsigned LEN_W = 10;
   localparam int unsigned TOTAL_W = 32;

   localparam logic [7:0] FRAME_END  = 8'hC0;
   localparam logic [7:0] FRAME_ESC  = 8'hDB;
   localparam logic [7:0] ESC_TO_END = 8'hDC;
   localparam logic [7:0] ESC_TO_ESC = 8'hDD;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_CRC_ERR = 2'd2,
      KIND_ABORT   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [7:0]           data_byte;
      logic [LEN_W-1:0]     payload_length;
      logic [TOTAL_W-1:0]   good_total;
      logic [TOTAL_W-1:0]   error_total;
   } result_type;

   // CRC-16/CCITT-FALSE, MSB first, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- rtl/slipcrc_core.sv -----
// Deframing state, two-byte hold, running CRC and frame counters.
// Depends on slipcrc_pkg.
module slipcrc_core import slipcrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       result_valid,
   output result_type result
);

   logic               inside_ff, inside_in;
   logic               esc_ff, esc_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [7:0]         hold0_ff, hold0_in;
   logic [7:0]         hold1_ff, hold1_in;
   logic [15:0]        crc_ff, crc_in;
   logic [TOTAL_W-1:0] good_ff, good_in;
   logic [TOTAL_W-1:0] err_ff, err_in;

   logic [7:0]       v;
   logic             skip;
   logic [CNT_W-1:0] len_full;
   kind_type         kind;
   logic [7:0]       data;
   logic [LEN_W-1:0] len;

   assign len_full = count_ff - CNT_W'(2);

   always_comb begin
      inside_in    = inside_ff;
      esc_in       = esc_ff;
      count_in     = count_ff;
      hold0_in     = hold0_ff;
      hold1_in     = hold1_ff;
      crc_in       = crc_ff;
      good_in      = good_ff;
      err_in       = err_ff;
      result_valid = 1'b0;
      kind         = KIND_PAYLOAD;
      data         = 8'h00;
      len          = '0;
      v            = rx_byte;
      skip         = 1'b0;
      priority if (rx_byte == FRAME_END) begin
         if (inside_ff && count_ff >= CNT_W'(2)) begin
            result_valid = 1'b1;
            len          = LEN_W'(len_full);
            if (crc_ff == {hold0_ff, hold1_ff}) begin
               good_in = good_ff + TOTAL_W'(1);
               kind    = KIND_GOOD;
            end else begin
               err_in = err_ff + TOTAL_W'(1);
               kind   = KIND_CRC_ERR;
            end
         end
         inside_in = 1'b1;
         esc_in    = 1'b0;
         count_in  = '0;
         crc_in    = CRC_INIT;
      end else if (inside_ff) begin
         if (esc_ff) begin
            esc_in = 1'b0;
            if (rx_byte == ESC_TO_END) begin
               v = FRAME_END;
            end else if (rx_byte == ESC_TO_ESC) begin
               v = FRAME_ESC;
            end
         end else if (rx_byte == FRAME_ESC) begin
            esc_in = 1'b1;
            skip   = 1'b1;
         end
         if (!skip) begin
            priority if (count_ff >= CNT_W'(MAX_FRAME_BYTES)) begin
               inside_in    = 1'b0;
               count_in     = '0;
               crc_in       = CRC_INIT;
               result_valid = 1'b1;
               kind         = KIND_ABORT;
            end else if (count_ff < CNT_W'(2)) begin
               if (count_ff[0]) begin
                  hold1_in = v;
               end else begin
                  hold0_in = v;
               end
               count_in = count_ff + CNT_W'(1);
            end else begin
               // release oldest held byte as payload
               crc_in       = crc16_byte(crc_ff, hold0_ff);
               hold0_in     = hold1_ff;
               hold1_in     = v;
               count_in     = count_ff + CNT_W'(1);
               result_valid = 1'b1;
               kind         = KIND_PAYLOAD;
               data         = hold0_ff;
            end
         end
      end else begin
         // outside a frame: byte dropped
      end
   end

   assign result.kind           = kind;
   assign result.data_byte      = data;
   assign result.payload_length = len;
   assign result.good_total     = good_in;
   assign result.error_total    = err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         esc_ff    <= 1'b0;
         count_ff  <= '0;
         hold0_ff  <= 8'h00;
         hold1_ff  <= 8'h00;
         crc_ff    <= CRC_INIT;
         good_ff   <= '0;
         err_ff    <= '0;
      end else if (step) begin
         inside_ff <= inside_in;
         esc_ff    <= esc_in;
         count_ff  <= count_in;
         hold0_ff  <= hold0_in;
         hold1_ff  <= hold1_in;
         crc_ff    <= crc_in;
         good_ff   <= good_in;
         err_ff    <= err_in;
      end
   end

endmodule

// ----- rtl/slip_crc16_deframer.sv -----
// SLIP deframer with CRC-16/CCITT-FALSE check: one received byte per request.
// A request goes to the input register, then any result to the result register.
// Throughput: one request per cycle while the result register is free or being taken.
// Reset (synchronous, active high) empties both registers, drops back to waiting
// for END, loads the CRC with FFFF and clears the frame counters.
module slip_crc16_deframer import slipcrc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [7:0]         rsp_data_byte,
   output logic [LEN_W-1:0]   rsp_payload_length,
   output logic [TOTAL_W-1:0] rsp_good_frame_total,
   output logic [TOTAL_W-1:0] rsp_crc_error_total
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // result register
   logic       out_valid_ff;
   result_type out_ff;

   logic       advance;
   logic       core_valid;
   result_type core_result;

   // The held request moves through the core whenever the result register
   // can take whatever it produces; requests with no result still need this
   // slot so ordering is kept.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   slipcrc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .rx_byte      (in_byte_ff),
      .result_valid (core_valid),
      .result       (core_result)
   );

   // result register: loads on a producing step, empties when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && core_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && core_valid) begin
         out_ff <= core_result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_kind             = out_ff.kind;
   assign rsp_data_byte        = out_ff.data_byte;
   assign rsp_payload_length   = out_ff.payload_length;
   assign rsp_good_frame_total = out_ff.good_total;
   assign rsp_crc_error_total  = out_ff.error_total;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for slip_crc16_deframer: a table of directed requests, then
// random SLIP frames under three pacing phases. Depends on slipcrc_pkg and the RTL.
module tb_top;
   import slipcrc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned PHASE_ITEMS = 280;

   // one decoder event as it should appear on the rsp_ side
   typedef struct {
      kind_type             kind;
      logic [7:0]           data;
      logic [LEN_W-1:0]     length;
      logic [TOTAL_W-1:0]   good_total;
      logic [TOTAL_W-1:0]   error_total;
   } frame_event_type;

   // how a directed row is checked: from the decoder model, known silent, or typed in
   typedef enum {ROW_PREDICT, ROW_SILENT, ROW_TYPED} row_mode_type;

   typedef struct {
      row_mode_type    mode;
      logic [7:0]      rx;
      frame_event_type want;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_rx_byte = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_kind;
   logic [7:0]           rsp_data_byte;
   logic [LEN_W-1:0]     rsp_payload_length;
   logic [TOTAL_W-1:0]   rsp_good_frame_total;
   logic [TOTAL_W-1:0]   rsp_crc_error_total;

   // decoder model state
   bit                   model_inside;
   bit                   esc_seen;
   logic [CNT_W-1:0]     stored_n;
   logic [7:0]           held [2];
   logic [15:0]          frame_crc;
   logic [TOTAL_W-1:0]   good_n;
   logic [TOTAL_W-1:0]   bad_n;

   frame_event_type      pending_events [$];
   stim_row_type         directed_rows [$];
   int unsigned          live_items;
   int unsigned          fail_count;
   int unsigned          cycle_count;
   int unsigned          req_gap_pct;
   int unsigned          rsp_gap_pct;
   int unsigned          hold_requests;
   int unsigned          hold_served;
   int unsigned          hold_left;

   slip_crc16_deframer u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_payload_length   (rsp_payload_length),
      .rsp_good_frame_total (rsp_good_frame_total),
      .rsp_crc_error_total  (rsp_crc_error_total)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // CRC-16/CCITT-FALSE worked one data bit at a time, MSB first
   function automatic logic [15:0] crc_ccitt_next(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ d[i];
         r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   function automatic frame_event_type make_event(input kind_type k, input logic [7:0] d,
                                                  input logic [LEN_W-1:0] len);
      frame_event_type ev;
      ev.kind        = k;
      ev.data        = d;
      ev.length      = len;
      ev.good_total  = good_n;
      ev.error_total = bad_n;
      return ev;
   endfunction

   // Advance the decoder model by one received byte; returns 1 when an event is due.
   function automatic bit deframe_step(input logic [7:0] b, output frame_event_type ev);
      logic [7:0]  v;
      logic [15:0] rx_crc;
      bit          yields;
      if (model_inside || b == FRAME_END) live_items++;
      if (b == FRAME_END) begin
         yields = model_inside && stored_n >= 2;
         if (yields) begin
            rx_crc = {held[0], held[1]};
            if (frame_crc == rx_crc) begin
               good_n++;
               ev = make_event(KIND_GOOD, 8'h00, LEN_W'(stored_n - 2));
            end else begin
               bad_n++;
               ev = make_event(KIND_CRC_ERR, 8'h00, LEN_W'(stored_n - 2));
            end
         end
         model_inside = 1'b1;
         esc_seen     = 1'b0;
         stored_n     = '0;
         frame_crc    = CRC_INIT;
         return yields;
      end
      if (!model_inside) return 1'b0;
      v = b;
      if (esc_seen) begin
         if (b == ESC_TO_END) v = FRAME_END;
         else if (b == ESC_TO_ESC) v = FRAME_ESC;
         esc_seen = 1'b0;
      end else if (b == FRAME_ESC) begin
         esc_seen = 1'b1;
         return 1'b0;
      end
      if (stored_n >= MAX_FRAME_BYTES) begin
         model_inside = 1'b0;
         stored_n     = '0;
         frame_crc    = CRC_INIT;
         ev = make_event(KIND_ABORT, 8'h00, '0);
         return 1'b1;
      end
      if (stored_n < 2) begin
         held[stored_n[0]] = v;
         stored_n++;
         return 1'b0;
      end
      // oldest held byte leaves as payload and joins the CRC
      ev = make_event(KIND_PAYLOAD, held[0], '0);
      frame_crc = crc_ccitt_next(frame_crc, held[0]);
      held[0] = held[1];
      held[1] = v;
      stored_n++;
      return 1'b1;
   endfunction

   // present one request at the falling edge, return at the edge that takes it
   task automatic drive_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_raw(input logic [7:0] b);
      frame_event_type ev;
      drive_byte(b);
      if (deframe_step(b, ev)) pending_events.push_back(ev);
   endtask

   task automatic send_decoded(input logic [7:0] v);
      if (v == FRAME_END) begin
         send_raw(FRAME_ESC);
         send_raw(ESC_TO_END);
      end else if (v == FRAME_ESC) begin
         send_raw(FRAME_ESC);
         send_raw(ESC_TO_ESC);
      end else begin
         send_raw(v);
      end
   endtask

   // random byte, leaning towards the SLIP control codes by special_pct
   function automatic logic [7:0] pick_byte(input int unsigned special_pct);
      if ($urandom_range(99) >= special_pct) return 8'($urandom_range(255));
      case ($urandom_range(3))
         0:       return FRAME_END;
         1:       return FRAME_ESC;
         2:       return ESC_TO_END;
         default: return ESC_TO_ESC;
      endcase
   endfunction

   // well-formed frame: payload, CRC big-endian (one bit flipped if asked), END
   task automatic send_frame(input int unsigned n, input bit corrupt);
      logic [15:0] crc;
      logic [7:0]  p;
      if (!model_inside || esc_seen || stored_n != 0) send_raw(FRAME_END);
      crc = CRC_INIT;
      repeat (n) begin
         p = pick_byte(12);
         crc = crc_ccitt_next(crc, p);
         send_decoded(p);
      end
      if (corrupt) crc ^= 16'(1 << $urandom_range(15));
      send_decoded(crc[15:8]);
      send_decoded(crc[7:0]);
      send_raw(FRAME_END);
   endtask

   task automatic wait_drained;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(input row_mode_type mode, input logic [7:0] rx,
                          input kind_type k = KIND_PAYLOAD, input logic [7:0] d = 8'h00,
                          input logic [LEN_W-1:0] len = '0,
                          input logic [TOTAL_W-1:0] good = '0,
                          input logic [TOTAL_W-1:0] bad = '0);
      stim_row_type row;
      row.mode             = mode;
      row.rx               = rx;
      row.want.kind        = k;
      row.want.data        = d;
      row.want.length      = len;
      row.want.good_total  = good;
      row.want.error_total = bad;
      directed_rows.push_back(row);
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
         fail_count++;
      end
   endtask

   // receiver pacing; a long hold is served whenever the sender asks for one
   always @(negedge clock) begin : rsp_pacer
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_gap_pct);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      frame_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected response, expected none actual kind %0d data %0h",
                     $time, rsp_kind, rsp_data_byte);
            fail_count++;
         end else begin
            want = pending_events.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_kind));
            check_field("data_byte", 32'(want.data), 32'(rsp_data_byte));
            check_field("payload_length", 32'(want.length), 32'(rsp_payload_length));
            check_field("good_frame_total", want.good_total, rsp_good_frame_total);
            check_field("crc_error_total", want.error_total, rsp_crc_error_total);
         end
      end
   end

   initial begin : stimulus
      frame_event_type ev;
      bit              yields;
      int unsigned     phase_end;

      model_inside = 1'b0;
      esc_seen     = 1'b0;
      stored_n     = '0;
      held[0]      = 8'h00;
      held[1]      = 8'h00;
      frame_crc    = CRC_INIT;
      good_n       = '0;
      bad_n        = '0;
      req_gap_pct = 28;
      rsp_gap_pct = 63;

      // noise before the first END is dropped silently
      add_row(ROW_SILENT, 8'h41);
      add_row(ROW_SILENT, FRAME_ESC);
      add_row(ROW_SILENT, 8'h00);
      add_row(ROW_SILENT, 8'hFF);
      add_row(ROW_SILENT, FRAME_END);
      // empty and one-byte frames only restart
      add_row(ROW_SILENT, FRAME_END);
      add_row(ROW_SILENT, 8'h55);
      add_row(ROW_SILENT, FRAME_END);
      // 00 00 00: one payload byte, then CRC 0000 fails
      add_row(ROW_SILENT, 8'h00);
      add_row(ROW_SILENT, 8'h00);
      add_row(ROW_TYPED, 8'h00, KIND_PAYLOAD, 8'h00, '0, '0, '0);
      add_row(ROW_TYPED, FRAME_END, KIND_CRC_ERR, 8'h00, LEN_W'(1), '0, TOTAL_W'(1));
      // single zero byte with its proper CRC
      add_row(ROW_PREDICT, 8'h00);
      add_row(ROW_PREDICT, 8'hE1);
      add_row(ROW_PREDICT, 8'hF0);
      add_row(ROW_PREDICT, FRAME_END);
      // both escapes, an unknown escape, then END straight after ESC
      add_row(ROW_PREDICT, FRAME_ESC);
      add_row(ROW_PREDICT, ESC_TO_END);
      add_row(ROW_PREDICT, FRAME_ESC);
      add_row(ROW_PREDICT, ESC_TO_ESC);
      add_row(ROW_PREDICT, FRAME_ESC);
      add_row(ROW_PREDICT, 8'h41);
      add_row(ROW_PREDICT, 8'hFF);
      add_row(ROW_PREDICT, FRAME_ESC);
      add_row(ROW_PREDICT, FRAME_END);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         drive_byte(directed_rows[i].rx);
         yields = deframe_step(directed_rows[i].rx, ev);
         case (directed_rows[i].mode)
            ROW_PREDICT: if (yields) pending_events.push_back(ev);
            ROW_TYPED:   pending_events.push_back(directed_rows[i].want);
            default:     ;
         endcase
      end

      // phases: receiver busy / sender brisk, then swapped, then flat out
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               req_gap_pct = 28;
               rsp_gap_pct = 63;
            end
            1: begin
               req_gap_pct = 63;
               rsp_gap_pct = 28;
            end
            default: begin
               req_gap_pct = 0;
               rsp_gap_pct = 0;
               // receiver stalls long while requests keep coming
               hold_requests++;
            end
         endcase
         phase_end = live_items + PHASE_ITEMS;
         while (live_items < phase_end) begin
            if ($urandom_range(99) < 75) begin
               send_frame(($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12),
                          $urandom_range(99) < 15);
            end else begin
               repeat ($urandom_range(1, 8)) send_raw(pick_byte(30));
            end
         end
         if (ph == 0) wait_drained();
      end

      // a frame that overruns and aborts, then a short one
      send_frame(MAX_FRAME_BYTES + 6, 1'b0);
      send_frame(3, 1'b0);

      wait_drained();
      repeat (16) @(posedge clock);
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/slipcrc_pkg.sv
rtl/slipcrc_core.sv
rtl/slip_crc16_deframer.sv
verif/tb_top.sv
